@@ design/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg
// types and codes shared by the section timing statistics table
// ----------------------------------------------------------------------------
package stt_pkg;

   typedef enum logic [1:0] {
      KIND_BEGIN = 2'd0,
      KIND_END   = 2'd1,
      KIND_READ  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
   localparam logic [1:0] STATUS_EMPTY   = 2'd3;

   localparam logic [47:0] DUR_ONES = {48{1'b1}};
   localparam logic [62:0] SUM_MAX  = {63{1'b1}};
   localparam logic [31:0] CALL_MAX = {32{1'b1}};

   typedef struct packed {
      logic [15:0] key;
      logic [47:0] start;
      logic [62:0] sum;
      logic [31:0] calls;
      logic [47:0] min0;
      logic [47:0] min1;
      logic [47:0] max0;
      logic [47:0] max1;
   } stat_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  slot;
      logic [15:0] key;
      logic [47:0] dur;
      logic [62:0] sum;
      logic [31:0] calls;
      logic [47:0] min0;
      logic [47:0] min1;
      logic [47:0] max0;
      logic [47:0] max1;
   } rsp_type;

endpackage

@@ design/section_timing_statistics_table.sv @@
// ----------------------------------------------------------------------------
// section_timing_statistics_table
// keyed table of timed sections with saturating totals, call counts and the
// two smallest and two largest durations per slot
// the request is captured into the stage registers at accept, and the result
// is registered from them into the response register
// busy blocks a new transaction after each accept, for the read-modify-write
// of the single-port statistics memory (key match is done at accept)
// reset empties the table by clearing the fill count; a slot's statistics are
// initialized when it is claimed, so no clearing pass runs
// the receiver cannot stall: rsp_valid is high for exactly one cycle
// ----------------------------------------------------------------------------
module section_timing_statistics_table #(
   parameter int ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_section_key,
   input  logic [47:0] req_timestamp,
   input  logic [5:0]  req_slot_index,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_slot,
   output logic [15:0] rsp_entry_key,
   output logic [47:0] rsp_last_duration,
   output logic [62:0] rsp_total_time,
   output logic [31:0] rsp_call_count,
   output logic [47:0] rsp_smallest,
   output logic [47:0] rsp_second_smallest,
   output logic [47:0] rsp_largest,
   output logic [47:0] rsp_second_largest
);

   localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   // key match
   logic [15:0]          cam_key_ff [ENTRIES];
   logic [CW-1:0]        count_ff, count_in;
   logic [ENTRIES-1:0]   hit;
   logic                 found;
   logic [SW-1:0]        hit_idx;
   logic                 full;
   logic                 accept;

   // stage registers
   logic                 busy_ff;
   stt_pkg::kind_type    kind_ff, kind_in;
   logic [15:0]          key_ff;
   logic [47:0]          ts_ff;
   logic [SW-1:0]        slot_ff, slot_in;
   logic [5:0]           rslot_ff, rslot_in;
   logic [1:0]           status_ff, status_in;
   logic                 ok_ff, ok_in;
   logic                 fresh_ff, fresh_in;
   logic                 claim;

   // statistics memory
   stt_pkg::stat_type    mem [ENTRIES];
   stt_pkg::stat_type    rd_ff;
   stt_pkg::stat_type    word, upd, init;
   logic                 wr_en;
   logic [47:0]          dur;
   logic [63:0]          sum_wide;
   logic [47:0]          lo1, hi1;

   logic                 rsp_valid_ff;
   stt_pkg::rsp_type     rsp_ff, rsp_in;

   assign accept = start && !busy_ff;
   assign full   = (count_ff == CW'(ENTRIES));

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit[i] = (CW'(i) < count_ff) && (cam_key_ff[i] == req_section_key);
      end
      found   = |hit;
      hit_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_idx = SW'(i);
         end
      end
   end

   always_comb begin
      kind_in   = stt_pkg::kind_type'(req_kind);
      slot_in   = '0;
      rslot_in  = '0;
      status_in = stt_pkg::STATUS_OK;
      ok_in     = 1'b0;
      fresh_in  = 1'b0;
      claim     = 1'b0;
      count_in  = count_ff;
      case (stt_pkg::kind_type'(req_kind))
         stt_pkg::KIND_BEGIN: begin
            if (found) begin
               slot_in = hit_idx;
               ok_in   = 1'b1;
            end else if (!full) begin
               slot_in  = count_ff[SW-1:0];
               ok_in    = 1'b1;
               fresh_in = 1'b1;
               claim    = 1'b1;
               count_in = count_ff + CW'(1);
            end else begin
               status_in = stt_pkg::STATUS_FULL;
            end
         end
         stt_pkg::KIND_END: begin
            if (found) begin
               slot_in = hit_idx;
               ok_in   = 1'b1;
            end else begin
               status_in = stt_pkg::STATUS_UNKNOWN;
            end
         end
         stt_pkg::KIND_READ: begin
            if (32'(req_slot_index) < 32'(count_ff)) begin
               slot_in = SW'(req_slot_index);
               ok_in   = 1'b1;
            end else begin
               status_in = stt_pkg::STATUS_EMPTY;
               rslot_in  = req_slot_index;
            end
         end
         stt_pkg::KIND_CLEAR: begin
            count_in = '0;
         end
         default: begin
            status_in = stt_pkg::STATUS_OK;
         end
      endcase
      if (ok_in) begin
         rslot_in = 6'(slot_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= accept;
         rsp_valid_ff <= busy_ff;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= kind_in;
         key_ff    <= req_section_key;
         ts_ff     <= req_timestamp;
         slot_ff   <= slot_in;
         rslot_ff  <= rslot_in;
         status_ff <= status_in;
         ok_ff     <= ok_in;
         fresh_ff  <= fresh_in;
         rd_ff     <= mem[slot_in];
         if (claim) begin
            cam_key_ff[count_ff[SW-1:0]] <= req_section_key;
         end
      end
      if (wr_en) begin
         mem[slot_ff] <= upd;
      end
      if (busy_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      init       = '0;
      init.key   = key_ff;
      init.min0  = stt_pkg::DUR_ONES;
      init.min1  = stt_pkg::DUR_ONES;
      word       = fresh_ff ? init : rd_ff;
      dur        = ts_ff - word.start;
      sum_wide   = {1'b0, word.sum} + {16'd0, dur};
      lo1        = (word.min1 > dur) ? dur : word.min1;
      hi1        = (word.max1 < dur) ? dur : word.max1;
      upd        = word;
      wr_en      = 1'b0;
      rsp_in     = '0;
      rsp_in.status = status_ff;
      rsp_in.slot   = rslot_ff;
      rsp_in.min0   = stt_pkg::DUR_ONES;
      rsp_in.min1   = stt_pkg::DUR_ONES;
      if (kind_ff == stt_pkg::KIND_END) begin
         upd.sum   = sum_wide[63] ? stt_pkg::SUM_MAX : sum_wide[62:0];
         upd.calls = (word.calls == stt_pkg::CALL_MAX) ? word.calls : word.calls + 32'd1;
         if (word.min0 > lo1) begin
            upd.min0 = lo1;
            upd.min1 = word.min0;
         end else begin
            upd.min0 = word.min0;
            upd.min1 = lo1;
         end
         if (word.max0 < hi1) begin
            upd.max0 = hi1;
            upd.max1 = word.max0;
         end else begin
            upd.max0 = word.max0;
            upd.max1 = hi1;
         end
      end else begin
         upd.start = ts_ff;
      end
      if (ok_ff) begin
         wr_en         = busy_ff && (kind_ff != stt_pkg::KIND_READ);
         rsp_in.status = stt_pkg::STATUS_OK;
         rsp_in.key    = upd.key;
         rsp_in.dur    = (kind_ff == stt_pkg::KIND_END) ? dur : 48'd0;
         rsp_in.sum    = upd.sum;
         rsp_in.calls  = upd.calls;
         rsp_in.min0   = upd.min0;
         rsp_in.min1   = upd.min1;
         rsp_in.max0   = upd.max0;
         rsp_in.max1   = upd.max1;
      end
   end

   assign busy                = busy_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_slot            = rsp_ff.slot;
   assign rsp_entry_key       = rsp_ff.key;
   assign rsp_last_duration   = rsp_ff.dur;
   assign rsp_total_time      = rsp_ff.sum;
   assign rsp_call_count      = rsp_ff.calls;
   assign rsp_smallest        = rsp_ff.min0;
   assign rsp_second_smallest = rsp_ff.min1;
   assign rsp_largest         = rsp_ff.max0;
   assign rsp_second_largest  = rsp_ff.max1;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("fill count beyond table size");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid_ff)
      else $error("transaction without result");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("busy held past one cycle");

   a_write_only_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (ok_ff && busy_ff && (kind_ff != stt_pkg::KIND_READ)))
      else $error("statistics written outside an update");

endmodule

@@ tb/section_timing_statistics_table_tb.sv @@
// ----------------------------------------------------------------------------
// section_timing_statistics_table_tb
// self-checking bench for the section timing statistics table: a directed
// table of extremes, unknown ends, empty reads, re-begins and clears, some
// rows with fixed expected results, then random traffic on small key pools
// and a full-table pass, checked against an in-bench model of the table
// ----------------------------------------------------------------------------
module section_timing_statistics_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = 64;
   localparam int CYCLE_LIMIT = 20_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = '0;
   logic [15:0] req_section_key = '0;
   logic [47:0] req_timestamp = '0;
   logic [5:0]  req_slot_index = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_slot;
   logic [15:0] rsp_entry_key;
   logic [47:0] rsp_last_duration;
   logic [62:0] rsp_total_time;
   logic [31:0] rsp_call_count;
   logic [47:0] rsp_smallest;
   logic [47:0] rsp_second_smallest;
   logic [47:0] rsp_largest;
   logic [47:0] rsp_second_largest;

   section_timing_statistics_table u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_section_key     (req_section_key),
      .req_timestamp       (req_timestamp),
      .req_slot_index      (req_slot_index),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_slot            (rsp_slot),
      .rsp_entry_key       (rsp_entry_key),
      .rsp_last_duration   (rsp_last_duration),
      .rsp_total_time      (rsp_total_time),
      .rsp_call_count      (rsp_call_count),
      .rsp_smallest        (rsp_smallest),
      .rsp_second_smallest (rsp_second_smallest),
      .rsp_largest         (rsp_largest),
      .rsp_second_largest  (rsp_second_largest)
   );

   always #4 clock = ~clock;

   // model of the table
   logic        tbl_used  [SLOTS];
   logic [15:0] tbl_key   [SLOTS];
   logic [47:0] tbl_start [SLOTS];
   logic [62:0] tbl_sum   [SLOTS];
   logic [31:0] tbl_calls [SLOTS];
   logic [47:0] tbl_min0  [SLOTS];
   logic [47:0] tbl_min1  [SLOTS];
   logic [47:0] tbl_max0  [SLOTS];
   logic [47:0] tbl_max1  [SLOTS];

   stt_pkg::rsp_type results_due [$];
   int               mismatches = 0;
   bit               idling = 1'b1;
   int unsigned      cycles = 0;

   typedef struct {
      stt_pkg::kind_type kind;
      logic [15:0]       key;
      logic [47:0]       ts;
      logic [5:0]        idx;
      bit                has_want;
      stt_pkg::rsp_type  want;
   } stim_row_type;

   stim_row_type directed_rows [$];

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < SLOTS; i++) begin
         tbl_used[i]  = 1'b0;
         tbl_key[i]   = '0;
         tbl_start[i] = '0;
         tbl_sum[i]   = '0;
         tbl_calls[i] = '0;
         tbl_min0[i]  = stt_pkg::DUR_ONES;
         tbl_min1[i]  = stt_pkg::DUR_ONES;
         tbl_max0[i]  = '0;
         tbl_max1[i]  = '0;
      end
   endfunction

   function automatic stt_pkg::rsp_type empty_result(logic [1:0] status,
                                                     logic [5:0] slot);
      stt_pkg::rsp_type r;
      r        = '0;
      r.status = status;
      r.slot   = slot;
      r.min0   = stt_pkg::DUR_ONES;
      r.min1   = stt_pkg::DUR_ONES;
      return r;
   endfunction

   function automatic stt_pkg::rsp_type fresh_slot(logic [5:0] slot, logic [15:0] key);
      stt_pkg::rsp_type r;
      r     = empty_result(stt_pkg::STATUS_OK, slot);
      r.key = key;
      return r;
   endfunction

   function automatic stt_pkg::rsp_type slot_stats(int s, logic [47:0] dur);
      stt_pkg::rsp_type r;
      r.status = stt_pkg::STATUS_OK;
      r.slot   = s[5:0];
      r.key    = tbl_key[s];
      r.dur    = dur;
      r.sum    = tbl_sum[s];
      r.calls  = tbl_calls[s];
      r.min0   = tbl_min0[s];
      r.min1   = tbl_min1[s];
      r.max0   = tbl_max0[s];
      r.max1   = tbl_max1[s];
      return r;
   endfunction

   // slot holding the key, else first free slot, else -1
   function automatic int find_slot(logic [15:0] key, output bit hit);
      hit = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!tbl_used[i]) return i;
         if (tbl_key[i] == key) begin
            hit = 1'b1;
            return i;
         end
      end
      return -1;
   endfunction

   function automatic stt_pkg::rsp_type apply_event(stt_pkg::kind_type kind,
                                                    logic [15:0] key,
                                                    logic [47:0] ts,
                                                    logic [5:0] idx);
      int          s;
      bit          hit;
      logic [47:0] dur;
      logic [47:0] held;
      case (kind)
         stt_pkg::KIND_BEGIN: begin
            s = find_slot(key, hit);
            if (s < 0) return empty_result(stt_pkg::STATUS_FULL, '0);
            if (!hit) begin
               tbl_used[s] = 1'b1;
               tbl_key[s]  = key;
            end
            tbl_start[s] = ts;
            return slot_stats(s, '0);
         end
         stt_pkg::KIND_END: begin
            s = find_slot(key, hit);
            if (!hit) return empty_result(stt_pkg::STATUS_UNKNOWN, '0);
            dur = ts - tbl_start[s];
            if (tbl_sum[s] > stt_pkg::SUM_MAX - 63'(dur)) tbl_sum[s] = stt_pkg::SUM_MAX;
            else tbl_sum[s] = tbl_sum[s] + 63'(dur);
            if (tbl_calls[s] != stt_pkg::CALL_MAX) tbl_calls[s] = tbl_calls[s] + 32'd1;
            if (tbl_min1[s] > dur) tbl_min1[s] = dur;
            if (tbl_max1[s] < dur) tbl_max1[s] = dur;
            if (tbl_max0[s] < tbl_max1[s]) begin
               held        = tbl_max0[s];
               tbl_max0[s] = tbl_max1[s];
               tbl_max1[s] = held;
            end
            if (tbl_min0[s] > tbl_min1[s]) begin
               held        = tbl_min0[s];
               tbl_min0[s] = tbl_min1[s];
               tbl_min1[s] = held;
            end
            return slot_stats(s, dur);
         end
         stt_pkg::KIND_READ: begin
            if (!tbl_used[idx]) return empty_result(stt_pkg::STATUS_EMPTY, idx);
            return slot_stats(int'(idx), '0);
         end
         default: begin
            clear_table();
            return empty_result(stt_pkg::STATUS_OK, '0);
         end
      endcase
   endfunction

   function automatic void add_row(stt_pkg::kind_type kind, logic [15:0] key,
                                   logic [47:0] ts, logic [5:0] idx,
                                   bit has_want = 1'b0,
                                   stt_pkg::rsp_type want = '0);
      stim_row_type row;
      row.kind     = kind;
      row.key      = key;
      row.ts       = ts;
      row.idx      = idx;
      row.has_want = has_want;
      row.want     = want;
      directed_rows.push_back(row);
   endfunction

   task automatic report(string what);
      $display("%0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   task automatic pause(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic issue(stt_pkg::kind_type kind, logic [15:0] key, logic [47:0] ts,
                        logic [5:0] idx);
      if (idling && $urandom_range(0, 3) == 0) pause($urandom_range(1, 7));
      @(negedge clock);
      start           <= 1'b1;
      req_kind        <= kind;
      req_section_key <= key;
      req_timestamp   <= ts;
      req_slot_index  <= idx;
      do @(posedge clock); while (busy);
      results_due.push_back(apply_event(kind, key, ts, idx));
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
   endtask

   // begin/end traffic on a small key pool, with reads, noise and clears
   task automatic random_run(int count);
      logic [15:0] pool [8];
      logic [47:0] stamp;
      int          pick;
      stamp = rand48();
      foreach (pool[i]) pool[i] = 16'($urandom);
      pool[0] = 16'h0000;
      pool[1] = 16'hFFFF;
      repeat (count) begin
         case ($urandom_range(0, 3))
            0: stamp = stamp + 48'($urandom_range(0, 15));
            1: stamp = stamp + 48'($urandom_range(0, 65535));
            2: stamp = stamp + 48'($urandom);
            default: stamp = rand48();
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 35)
            issue(stt_pkg::KIND_BEGIN, pool[$urandom_range(0, 7)], stamp,
                  6'($urandom));
         else if (pick < 70)
            issue(stt_pkg::KIND_END, pool[$urandom_range(0, 7)], stamp,
                  6'($urandom));
         else if (pick < 85)
            issue(stt_pkg::KIND_READ, 16'($urandom), rand48(),
                  6'($urandom_range(0, 9)));
         else if (pick < 95)
            issue(stt_pkg::kind_type'($urandom_range(0, 1)), 16'($urandom), rand48(),
                  6'($urandom));
         else if (pick < 98)
            issue(stt_pkg::KIND_READ, 16'($urandom), rand48(), 6'($urandom));
         else
            issue(stt_pkg::KIND_CLEAR, 16'($urandom), rand48(), 6'($urandom));
      end
   endtask

   // clear, claim every slot, then hit the full table with new keys, begins, ends and reads
   task automatic fill_table();
      logic [15:0] key;
      bit          hit;
      issue(stt_pkg::KIND_CLEAR, 16'($urandom), rand48(), 6'($urandom));
      for (int i = 0; i < SLOTS; i++)
         issue(stt_pkg::KIND_BEGIN, {6'(i), 10'($urandom)}, rand48(), 6'($urandom));
      repeat (3) begin
         do key = 16'($urandom); while (find_slot(key, hit) >= 0);
         issue(stt_pkg::KIND_BEGIN, key, rand48(), 6'($urandom));
      end
      repeat (10) issue(stt_pkg::KIND_BEGIN, tbl_key[$urandom_range(0, SLOTS - 1)],
                        rand48(), 6'($urandom));
      repeat (20) issue(stt_pkg::KIND_END, tbl_key[$urandom_range(0, SLOTS - 1)],
                        rand48(), 6'($urandom));
      for (int i = 0; i < SLOTS; i++)
         issue(stt_pkg::KIND_READ, 16'($urandom), rand48(), 6'(i));
   endtask

   always @(posedge clock) begin
      stt_pkg::rsp_type oldest;
      if (!reset && rsp_valid) begin
         if (results_due.size() == 0) begin
            report("result with no transaction pending");
         end else begin
            oldest = results_due.pop_front();
            check_field("status", 64'(rsp_status), 64'(oldest.status));
            check_field("slot", 64'(rsp_slot), 64'(oldest.slot));
            check_field("entry_key", 64'(rsp_entry_key), 64'(oldest.key));
            check_field("last_duration", 64'(rsp_last_duration), 64'(oldest.dur));
            check_field("total_time", 64'(rsp_total_time), 64'(oldest.sum));
            check_field("call_count", 64'(rsp_call_count), 64'(oldest.calls));
            check_field("smallest", 64'(rsp_smallest), 64'(oldest.min0));
            check_field("second_smallest", 64'(rsp_second_smallest),
                        64'(oldest.min1));
            check_field("largest", 64'(rsp_largest), 64'(oldest.max0));
            check_field("second_largest", 64'(rsp_second_largest),
                        64'(oldest.max1));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      stim_row_type     row;
      stt_pkg::rsp_type first_end;
      clear_table();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      first_end = '{status: stt_pkg::STATUS_OK, slot: 6'd0, key: 16'h0000,
                    dur: stt_pkg::DUR_ONES, sum: 63'(stt_pkg::DUR_ONES),
                    calls: 32'd1, min0: stt_pkg::DUR_ONES, min1: stt_pkg::DUR_ONES,
                    max0: stt_pkg::DUR_ONES, max1: 48'd0};

      add_row(stt_pkg::KIND_READ, 16'h0000, 48'h0, 6'd0, 1'b1,
              empty_result(stt_pkg::STATUS_EMPTY, 6'd0));
      add_row(stt_pkg::KIND_READ, 16'hFFFF, stt_pkg::DUR_ONES, 6'd63, 1'b1,
              empty_result(stt_pkg::STATUS_EMPTY, 6'd63));
      add_row(stt_pkg::KIND_END, 16'h1234, 48'h0, 6'd0, 1'b1,
              empty_result(stt_pkg::STATUS_UNKNOWN, 6'd0));
      add_row(stt_pkg::KIND_BEGIN, 16'h0000, 48'h0, 6'd0, 1'b1,
              fresh_slot(6'd0, 16'h0000));
      add_row(stt_pkg::KIND_END, 16'h0000, stt_pkg::DUR_ONES, 6'd0, 1'b1, first_end);
      add_row(stt_pkg::KIND_BEGIN, 16'hFFFF, stt_pkg::DUR_ONES, 6'd63, 1'b1,
              fresh_slot(6'd1, 16'hFFFF));
      add_row(stt_pkg::KIND_END, 16'hFFFF, 48'h0, 6'd0);
      add_row(stt_pkg::KIND_END, 16'hFFFF, 48'h5, 6'd0);
      add_row(stt_pkg::KIND_BEGIN, 16'h0000, 48'd100, 6'd0);
      add_row(stt_pkg::KIND_END, 16'h0000, 48'd100, 6'd0);
      add_row(stt_pkg::KIND_END, 16'h0000, 48'd50, 6'd0);
      add_row(stt_pkg::KIND_END, 16'h0000, 48'h8000_0000_0000, 6'd0);
      add_row(stt_pkg::KIND_READ, 16'h0000, 48'h0, 6'd1);
      add_row(stt_pkg::KIND_READ, 16'h0000, 48'h0, 6'd2, 1'b1,
              empty_result(stt_pkg::STATUS_EMPTY, 6'd2));
      add_row(stt_pkg::KIND_BEGIN, 16'h5555, 48'h5555_5555_5555, 6'h2A);
      add_row(stt_pkg::KIND_END, 16'h5555, 48'hAAAA_AAAA_AAAA, 6'h15);
      add_row(stt_pkg::KIND_READ, 16'hAAAA, stt_pkg::DUR_ONES, 6'd2);
      add_row(stt_pkg::KIND_END, 16'hAAAA, 48'h0, 6'd0, 1'b1,
              empty_result(stt_pkg::STATUS_UNKNOWN, 6'd0));
      add_row(stt_pkg::KIND_CLEAR, 16'hFFFF, stt_pkg::DUR_ONES, 6'd63, 1'b1,
              empty_result(stt_pkg::STATUS_OK, 6'd0));
      add_row(stt_pkg::KIND_READ, 16'h0000, 48'h0, 6'd0, 1'b1,
              empty_result(stt_pkg::STATUS_EMPTY, 6'd0));
      add_row(stt_pkg::KIND_END, 16'h0000, 48'h0, 6'd0, 1'b1,
              empty_result(stt_pkg::STATUS_UNKNOWN, 6'd0));
      add_row(stt_pkg::KIND_BEGIN, 16'hFFFF, 48'h0, 6'd63, 1'b1,
              fresh_slot(6'd0, 16'hFFFF));
      add_row(stt_pkg::KIND_CLEAR, 16'h0000, 48'h0, 6'd0, 1'b1,
              empty_result(stt_pkg::STATUS_OK, 6'd0));

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         issue(row.kind, row.key, row.ts, row.idx);
         if (row.has_want) results_due[results_due.size() - 1] = row.want;
      end

      random_run(100);
      fill_table();
      drain();
      random_run(60);
      idling = 1'b0;
      random_run(60);
      drain();
      repeat (4) @(posedge clock);

      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

@@ files.f @@
design/stt_pkg.sv
design/section_timing_statistics_table.sv
tb/section_timing_statistics_table_tb.sv
